FILE: design/tvs_pkg.sv
`timescale 1ns / 1ps
package tvs_pkg;

   // Default build parameters
   localparam int MAX_NODES_DEF  = 256;
   localparam int FRAC_BITS_DEF  = 16;

   // Fixed field widths
   localparam int VALUE_W        = 17;
   localparam int MARGIN_W       = 16;
   localparam int NODE_OUT_W     = 8;
   localparam int NODE_COUNT_W   = 9;
   localparam int COUNT_W        = 2;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;

   // Configuration port
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_Y_TERM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN     = 2'd2;
   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 9'd3;

   // Cut cap thresholds on the node count
   localparam int CAP_FREE_NODES = 100;
   localparam int CAP3_NODES     = 150;
   localparam int CAP2_NODES     = 200;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_START   = 2'd1,
      CMD_EXAMINE = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PAIR_AB = 2'd0,
      PAIR_AC = 2'd1,
      PAIR_BC = 2'd2
   } pair_sel_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [VALUE_W-1:0]     edge_value;
   } req_payload_type;

   typedef struct packed {
      logic [NODE_OUT_W-1:0]  node_a;
      logic [NODE_OUT_W-1:0]  node_b;
      logic [NODE_OUT_W-1:0]  node_c;
      logic                   cut_ab;
      logic                   cut_ac;
      logic                   cut_bc;
      logic                   with_node_term;
      logic                   scan_done;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic          clear_step;
      logic          load_wr;
      logic          rewind;
      logic          capture;
      logic          mul_a;
      logic          mul_b;
      pair_sel_type  rd_sel;
      logic          latch_en;
      pair_sel_type  latch_sel;
      logic          decide;
      logic          wr_en;
      pair_sel_type  wr_sel;
      logic          out_load;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic          triple_ok;
      logic          clear_last;
      logic          out_busy;
   } dp_status_type;

endpackage

FILE: design/tvs_stream_if.sv
`timescale 1ns / 1ps
interface tvs_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/tvs_ram.sv
`timescale 1ns / 1ps
module tvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/tvs_ctrl.sv
`timescale 1ns / 1ps
module tvs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  tvs_pkg::cmd_type        req_cmd,
   input  tvs_pkg::dp_status_type  status,
   output tvs_pkg::dp_cmd_type     dp_cmd,
   output logic                    req_ready
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MUL_A, ST_MUL_B, ST_RD_AB, ST_RD_AC, ST_RD_BC,
      ST_EVAL, ST_DECIDE, ST_WR_AB, ST_WR_AC, ST_WR_BC, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Sequence one transaction
   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  tvs_pkg::CMD_LOAD: dp_cmd.load_wr = 1'b1;
                  tvs_pkg::CMD_START: begin
                     dp_cmd.rewind = 1'b1;
                     state_in      = ST_CLEAR;
                  end
                  tvs_pkg::CMD_EXAMINE: begin
                     dp_cmd.capture = 1'b1;
                     state_in       = status.triple_ok ? ST_MUL_A : ST_OUT;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL_A: begin
            dp_cmd.mul_a = 1'b1;
            state_in     = ST_MUL_B;
         end
         ST_MUL_B: begin
            dp_cmd.mul_b = 1'b1;
            state_in     = ST_RD_AB;
         end
         ST_RD_AB: begin
            dp_cmd.rd_sel = tvs_pkg::PAIR_AB;
            state_in      = ST_RD_AC;
         end
         ST_RD_AC: begin
            dp_cmd.rd_sel    = tvs_pkg::PAIR_AC;
            dp_cmd.latch_en  = 1'b1;
            dp_cmd.latch_sel = tvs_pkg::PAIR_AB;
            state_in         = ST_RD_BC;
         end
         ST_RD_BC: begin
            dp_cmd.rd_sel    = tvs_pkg::PAIR_BC;
            dp_cmd.latch_en  = 1'b1;
            dp_cmd.latch_sel = tvs_pkg::PAIR_AC;
            state_in         = ST_EVAL;
         end
         ST_EVAL: begin
            dp_cmd.latch_en  = 1'b1;
            dp_cmd.latch_sel = tvs_pkg::PAIR_BC;
            state_in         = ST_DECIDE;
         end
         ST_DECIDE: begin
            dp_cmd.decide = 1'b1;
            state_in      = ST_WR_AB;
         end
         ST_WR_AB: begin
            dp_cmd.wr_en  = 1'b1;
            dp_cmd.wr_sel = tvs_pkg::PAIR_AB;
            state_in      = ST_WR_AC;
         end
         ST_WR_AC: begin
            dp_cmd.wr_en  = 1'b1;
            dp_cmd.wr_sel = tvs_pkg::PAIR_AC;
            state_in      = ST_WR_BC;
         end
         ST_WR_BC: begin
            dp_cmd.wr_en  = 1'b1;
            dp_cmd.wr_sel = tvs_pkg::PAIR_BC;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               dp_cmd.out_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end
endmodule

FILE: design/tvs_datapath.sv
`timescale 1ns / 1ps
module tvs_datapath #(
   parameter int MAX_NODES           = tvs_pkg::MAX_NODES_DEF,
   parameter int VALUE_FRACTION_BITS = tvs_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tvs_pkg::dp_cmd_type               dp_cmd,
   output tvs_pkg::dp_status_type            status,
   input  tvs_pkg::req_payload_type          req_payload,
   input  logic                              csr_wr_en,
   input  logic [tvs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tvs_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output tvs_pkg::rsp_payload_type          rsp_payload
);
   localparam int PAIR_SLOTS = (MAX_NODES * (MAX_NODES - 1)) / 2;
   localparam int ADDR_W     = $clog2(PAIR_SLOTS);
   localparam int PTR_W      = $clog2(PAIR_SLOTS + 1);
   localparam int NODE_W     = $clog2(MAX_NODES + 1);
   localparam int CMP_W      = NODE_W > tvs_pkg::NODE_COUNT_W ? NODE_W : tvs_pkg::NODE_COUNT_W;
   localparam int PROD_W     = 2 * NODE_W + 1;
   localparam int SUM_W      = (VALUE_FRACTION_BITS + 1 > tvs_pkg::VALUE_W ?
                                VALUE_FRACTION_BITS + 1 : tvs_pkg::VALUE_W) + 2;
   localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << VALUE_FRACTION_BITS;

   localparam int VW = tvs_pkg::VALUE_W;
   localparam int CW = tvs_pkg::COUNT_W;

   // Configuration registers
   logic [tvs_pkg::NODE_COUNT_W-1:0] node_count_ff;
   logic                             use_y_term_ff;
   logic [tvs_pkg::MARGIN_W-1:0]     margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= tvs_pkg::NODE_COUNT_RESET;
         use_y_term_ff <= 1'b0;
         margin_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            tvs_pkg::CSR_NODE_COUNT:
               node_count_ff <= csr_wr_data[tvs_pkg::NODE_COUNT_W-1:0];
            tvs_pkg::CSR_USE_Y_TERM: use_y_term_ff <= csr_wr_data[0];
            tvs_pkg::CSR_MARGIN:     margin_ff <= csr_wr_data[tvs_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp node count to the build limit
   logic [NODE_W-1:0] n_eff;
   assign n_eff = (CMP_W'(node_count_ff) > CMP_W'(MAX_NODES)) ? NODE_W'(MAX_NODES)
                                                             : NODE_W'(node_count_ff);

   // Number of pairs that may be loaded
   logic [PTR_W-1:0]    pair_limit;
   logic [2*NODE_W-1:0] pair_prod;
   assign pair_prod  = (2*NODE_W)'(n_eff) * (2*NODE_W)'(n_eff - NODE_W'(1));
   assign pair_limit = (n_eff < NODE_W'(2)) ? '0 : PTR_W'(pair_prod >> 1);

   // Load pointer, triple and clear sweep pointer
   logic [PTR_W-1:0]  load_ptr_ff;
   logic [NODE_W-1:0] a_ff, b_ff, c_ff;
   logic [NODE_W-1:0] a_in, b_in, c_in;
   logic [ADDR_W-1:0] clr_ptr_ff;
   logic              ok_ff;
   logic              load_ok;

   assign load_ok = dp_cmd.load_wr && (load_ptr_ff < pair_limit);
   assign status.triple_ok  = (c_ff < n_eff) && (b_ff < c_ff) && (a_ff < b_ff);
   assign status.clear_last = (clr_ptr_ff == ADDR_W'(PAIR_SLOTS - 1));

   // Advance to the next triple in lexicographic order
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff + NODE_W'(1);
      if (c_in >= n_eff) begin
         b_in = b_ff + NODE_W'(1);
         c_in = b_ff + NODE_W'(2);
         if (c_in >= n_eff) begin
            a_in = a_ff + NODE_W'(1);
            b_in = a_ff + NODE_W'(2);
            c_in = a_ff + NODE_W'(3);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
         a_ff        <= NODE_W'(0);
         b_ff        <= NODE_W'(1);
         c_ff        <= NODE_W'(2);
         clr_ptr_ff  <= '0;
         ok_ff       <= 1'b0;
      end else begin
         if (dp_cmd.rewind) begin
            load_ptr_ff <= '0;
            a_ff        <= NODE_W'(0);
            b_ff        <= NODE_W'(1);
            c_ff        <= NODE_W'(2);
         end else begin
            if (load_ok) load_ptr_ff <= load_ptr_ff + PTR_W'(1);
            if (dp_cmd.out_load && ok_ff) begin
               a_ff <= a_in;
               b_ff <= b_in;
               c_ff <= c_in;
            end
         end
         if (dp_cmd.clear_step) begin
            clr_ptr_ff <= status.clear_last ? '0 : clr_ptr_ff + ADDR_W'(1);
         end
         if (dp_cmd.capture) ok_ff <= status.triple_ok;
      end
   end

   // Row base i*(2n-i-1)/2 through one shared multiplier
   logic [ADDR_W-1:0] base_a_ff, base_b_ff;
   logic [NODE_W-1:0] mul_op;
   logic [NODE_W:0]   mul_factor;
   logic [PROD_W-1:0] mul_prod;

   assign mul_op     = dp_cmd.mul_b ? b_ff : a_ff;
   assign mul_factor = {n_eff, 1'b0} - (NODE_W+1)'(mul_op) - (NODE_W+1)'(1);
   assign mul_prod   = PROD_W'(mul_op) * PROD_W'(mul_factor);

   always_ff @(posedge clock) begin
      if (dp_cmd.mul_a) base_a_ff <= ADDR_W'(mul_prod >> 1);
      if (dp_cmd.mul_b) base_b_ff <= ADDR_W'(mul_prod >> 1);
   end

   // Pair addresses
   logic [ADDR_W-1:0] addr_ab, addr_ac, addr_bc, rd_addr, wr_pair_addr;
   assign addr_ab = base_a_ff + ADDR_W'(b_ff - a_ff - NODE_W'(1));
   assign addr_ac = base_a_ff + ADDR_W'(c_ff - a_ff - NODE_W'(1));
   assign addr_bc = base_b_ff + ADDR_W'(c_ff - b_ff - NODE_W'(1));

   always_comb begin
      case (dp_cmd.rd_sel)
         tvs_pkg::PAIR_AB: rd_addr = addr_ab;
         tvs_pkg::PAIR_AC: rd_addr = addr_ac;
         tvs_pkg::PAIR_BC: rd_addr = addr_bc;
         default:          rd_addr = addr_ab;
      endcase
      case (dp_cmd.wr_sel)
         tvs_pkg::PAIR_AB: wr_pair_addr = addr_ab;
         tvs_pkg::PAIR_AC: wr_pair_addr = addr_ac;
         tvs_pkg::PAIR_BC: wr_pair_addr = addr_bc;
         default:          wr_pair_addr = addr_ab;
      endcase
   end

   // Pair value store
   logic [VW-1:0] val_rd;
   tvs_ram #(.WIDTH(VW), .DEPTH(PAIR_SLOTS)) u_values (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (load_ptr_ff[ADDR_W-1:0]),
      .wr_data (req_payload.edge_value),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   // Cut counter store
   logic [CW-1:0]     cnt_rd, cnt_sel, cnt_wr_data;
   logic [ADDR_W-1:0] cnt_wr_addr;
   logic              cnt_wr_en, flag_sel;
   logic [2:0]        flags_ff;
   logic [CW-1:0]     c_ab_ff, c_ac_ff, c_bc_ff;

   always_comb begin
      case (dp_cmd.wr_sel)
         tvs_pkg::PAIR_AB: begin cnt_sel = c_ab_ff; flag_sel = flags_ff[0]; end
         tvs_pkg::PAIR_AC: begin cnt_sel = c_ac_ff; flag_sel = flags_ff[1]; end
         tvs_pkg::PAIR_BC: begin cnt_sel = c_bc_ff; flag_sel = flags_ff[2]; end
         default:          begin cnt_sel = c_ab_ff; flag_sel = flags_ff[0]; end
      endcase
      if (dp_cmd.clear_step) begin
         cnt_wr_en   = 1'b1;
         cnt_wr_addr = clr_ptr_ff;
         cnt_wr_data = '0;
      end else begin
         cnt_wr_en   = dp_cmd.wr_en && flag_sel;
         cnt_wr_addr = wr_pair_addr;
         cnt_wr_data = (cnt_sel == tvs_pkg::COUNT_MAX) ? cnt_sel : cnt_sel + CW'(1);
      end
   end

   tvs_ram #(.WIDTH(CW), .DEPTH(PAIR_SLOTS)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd)
   );

   // Latch read data per pair
   logic [VW-1:0] v_ab_ff, v_ac_ff, v_bc_ff;
   always_ff @(posedge clock) begin
      if (dp_cmd.latch_en) begin
         case (dp_cmd.latch_sel)
            tvs_pkg::PAIR_AB: begin v_ab_ff <= val_rd; c_ab_ff <= cnt_rd; end
            tvs_pkg::PAIR_AC: begin v_ac_ff <= val_rd; c_ac_ff <= cnt_rd; end
            tvs_pkg::PAIR_BC: begin v_bc_ff <= val_rd; c_bc_ff <= cnt_rd; end
            default: ;
         endcase
      end
   end

   // Test the three cuts against margin and cap
   logic [SUM_W-1:0] thr_ab, thr_ac, thr_bc;
   logic             cap_free;
   logic [CW-1:0]    cap;
   logic [2:0]       flags_in;

   assign thr_ab = SUM_W'(v_ab_ff) + ONE + SUM_W'(margin_ff);
   assign thr_ac = SUM_W'(v_ac_ff) + ONE + SUM_W'(margin_ff);
   assign thr_bc = SUM_W'(v_bc_ff) + ONE + SUM_W'(margin_ff);
   assign cap_free = int'(n_eff) <= tvs_pkg::CAP_FREE_NODES;
   assign cap = (int'(n_eff) <= tvs_pkg::CAP3_NODES) ? CW'(3) :
                (int'(n_eff) <= tvs_pkg::CAP2_NODES) ? CW'(2) : CW'(1);

   always_comb begin
      flags_in[0] = (SUM_W'(v_ac_ff) + SUM_W'(v_bc_ff) > thr_ab) &&
                    (cap_free || c_ab_ff < cap);
      flags_in[1] = (SUM_W'(v_ab_ff) + SUM_W'(v_bc_ff) > thr_ac) &&
                    (cap_free || c_ac_ff < cap);
      flags_in[2] = (SUM_W'(v_ab_ff) + SUM_W'(v_ac_ff) > thr_bc) &&
                    (cap_free || c_bc_ff < cap);
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.decide) flags_ff <= flags_in;
   end

   // Output register
   logic                     rsp_valid_ff;
   tvs_pkg::rsp_payload_type rsp_payload_ff;
   tvs_pkg::rsp_payload_type done_payload;

   always_comb begin
      done_payload           = '0;
      done_payload.scan_done = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.out_load) begin
         if (ok_ff) begin
            rsp_payload_ff.node_a         <= tvs_pkg::NODE_OUT_W'(a_ff);
            rsp_payload_ff.node_b         <= tvs_pkg::NODE_OUT_W'(b_ff);
            rsp_payload_ff.node_c         <= tvs_pkg::NODE_OUT_W'(c_ff);
            rsp_payload_ff.cut_ab         <= flags_ff[0];
            rsp_payload_ff.cut_ac         <= flags_ff[1];
            rsp_payload_ff.cut_bc         <= flags_ff[2];
            rsp_payload_ff.with_node_term <= use_y_term_ff;
            rsp_payload_ff.scan_done      <= 1'b0;
         end else begin
            rsp_payload_ff <= done_payload;
         end
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_payload_ff;
endmodule

FILE: design/triangle_violation_scanner_top.sv
`timescale 1ns / 1ps
// Triangle violation scanner.
// req_if carries commands: load (next pair value, upper-triangle row-major),
// start (clear cut counters, rewind the triple and the load pointer),
// examine (test the next triple a<b<c). Only examine yields a transaction on
// rsp_if: the triple, three cut flags, the node-term mark and scan_done.
// csr_* writes node_count, use_y_term and violation_margin at any time the
// block is idle; writes take effect on the next cycle.
// Load and no-op are handled in the idle state, which stays ready for the
// next command. An examine runs two row-base multiplies on one shared
// multiplier, three reads of the value and counter memories, a latch and a
// compare step and three counter writes, one transaction at a time, then
// loads the result register and only then takes the next command. A
// finished scan goes straight to the result load, then takes the next one.
// Reset and start both run a clearing pass over the counter memory, one
// entry a cycle across MAX_NODES*(MAX_NODES-1)/2 entries (32640 by default),
// with req_if.ready low. Configuration writes are still taken during the pass.
// A held result waits in the output register while the next command is
// taken; an examine that finishes while rsp_if is stalled waits for it.
module triangle_violation_scanner_top #(
   parameter int MAX_NODES           = tvs_pkg::MAX_NODES_DEF,
   parameter int VALUE_FRACTION_BITS = tvs_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tvs_stream_if.sink                      req_if,
   tvs_stream_if.source                    rsp_if,
   input  logic                            csr_wr_en,
   input  logic [tvs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tvs_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   tvs_pkg::dp_cmd_type      dp_cmd;
   tvs_pkg::dp_status_type   dp_status;
   tvs_pkg::req_payload_type req_payload;
   tvs_pkg::rsp_payload_type rsp_payload;
   logic                     req_fire;
   logic                     req_ready;
   logic                     rsp_valid;

   assign req_payload  = req_if.payload;
   assign req_fire     = req_if.valid && req_ready;
   assign req_if.ready = req_ready;

   tvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_cmd   (req_payload.cmd),
      .status    (dp_status),
      .dp_cmd    (dp_cmd),
      .req_ready (req_ready)
   );

   tvs_datapath #(
      .MAX_NODES           (MAX_NODES),
      .VALUE_FRACTION_BITS (VALUE_FRACTION_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .status      (dp_status),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_payload;

   // No command is taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.clear_step |-> !req_ready)
      else $error("command accepted during counter clear");

   // An examine blocks the next command
   a_examine_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.cmd == tvs_pkg::CMD_EXAMINE) |=> !req_ready)
      else $error("command accepted while examine in progress");

   // Never overwrite a result that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> !dp_status.out_busy)
      else $error("stalled result overwritten");

   // A finished scan carries no cut flags
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.scan_done) |->
         !(rsp_payload.cut_ab || rsp_payload.cut_ac || rsp_payload.cut_bc))
      else $error("cut flag raised with scan_done");
endmodule

FILE: verif/triangle_violation_scanner_checker.sv
`timescale 1ns / 1ps
module triangle_violation_scanner_checker
   import tvs_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  req_payload_type                 req_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  rsp_payload_type                 rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]           csr_wr_data,
   output int                              fail_count,
   output int                              pending,
   output int                              triples_seen
);
   localparam int SLOTS = (MAX_NODES_DEF * (MAX_NODES_DEF - 1)) / 2;

   // Shadow copy of the block's configuration and state
   logic [NODE_COUNT_W-1:0] nodes_cfg;
   logic                    y_term_cfg;
   logic [MARGIN_W-1:0]     margin_cfg;
   logic [VALUE_W-1:0]      edge_store [SLOTS];
   logic [COUNT_W-1:0]      cut_counts [SLOTS];
   int                      load_ptr;
   int                      tri_a, tri_b, tri_c;
   rsp_payload_type         expected_rsp [$];

   function automatic int pair_slot(int i, int j, int n);
      int idx;
      idx = i * n - (i * (i + 1)) / 2 + (j - i - 1);
      return (idx < SLOTS) ? idx : 0;
   endfunction

   // Test one cut on pair p against the other two pair values
   function automatic logic cut_fires(int p, int q, int r, int cap);
      longint excess;
      excess = longint'(edge_store[q]) + longint'(edge_store[r])
               - longint'(edge_store[p]) - (longint'(1) << FRAC_BITS_DEF);
      if (excess > longint'(margin_cfg) && int'(cut_counts[p]) < cap) begin
         if (cut_counts[p] != COUNT_MAX) cut_counts[p] = cut_counts[p] + 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Work out the outcome of one accepted command
   task automatic predict_command(req_payload_type t);
      int n, npairs, cap, iab, iac, ibc;
      rsp_payload_type r;
      n = (nodes_cfg > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(nodes_cfg);
      r = '0;
      case (t.cmd)
         CMD_LOAD: begin
            npairs = (n >= 2) ? (n * (n - 1)) / 2 : 0;
            if (load_ptr < npairs && load_ptr < SLOTS) begin
               edge_store[load_ptr] = t.edge_value;
               load_ptr++;
            end
         end
         CMD_START: begin
            foreach (cut_counts[k]) cut_counts[k] = '0;
            tri_a = 0; tri_b = 1; tri_c = 2;
            load_ptr = 0;
         end
         CMD_EXAMINE: begin
            if (tri_c >= n || tri_b >= tri_c || tri_a >= tri_b) begin
               r.scan_done = 1'b1;
            end else begin
               iab = pair_slot(tri_a, tri_b, n);
               iac = pair_slot(tri_a, tri_c, n);
               ibc = pair_slot(tri_b, tri_c, n);
               if (n <= CAP_FREE_NODES) cap = 4;
               else if (n <= CAP3_NODES) cap = 3;
               else if (n <= CAP2_NODES) cap = 2;
               else cap = 1;
               r.node_a = tri_a[7:0];
               r.node_b = tri_b[7:0];
               r.node_c = tri_c[7:0];
               r.cut_ab = cut_fires(iab, iac, ibc, cap);
               r.cut_ac = cut_fires(iac, iab, ibc, cap);
               r.cut_bc = cut_fires(ibc, iab, iac, cap);
               r.with_node_term = y_term_cfg;
               // advance to the next triple
               tri_c++;
               if (tri_c >= n) begin
                  tri_b++;
                  tri_c = tri_b + 1;
                  if (tri_c >= n) begin
                     tri_a++;
                     tri_b = tri_a + 1;
                     tri_c = tri_b + 1;
                  end
               end
            end
            expected_rsp = {expected_rsp, r};
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic compare_result(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch("unexpected result transaction", 1, 0);
      end else begin
         want = expected_rsp.pop_front();
         if (got.node_a !== want.node_a) report_mismatch("node_a", got.node_a, want.node_a);
         if (got.node_b !== want.node_b) report_mismatch("node_b", got.node_b, want.node_b);
         if (got.node_c !== want.node_c) report_mismatch("node_c", got.node_c, want.node_c);
         if (got.cut_ab !== want.cut_ab) report_mismatch("cut_ab", got.cut_ab, want.cut_ab);
         if (got.cut_ac !== want.cut_ac) report_mismatch("cut_ac", got.cut_ac, want.cut_ac);
         if (got.cut_bc !== want.cut_bc) report_mismatch("cut_bc", got.cut_bc, want.cut_bc);
         if (got.with_node_term !== want.with_node_term)
            report_mismatch("with_node_term", got.with_node_term, want.with_node_term);
         if (got.scan_done !== want.scan_done)
            report_mismatch("scan_done", got.scan_done, want.scan_done);
         if (!want.scan_done) triples_seen++;
      end
   endtask

   // Track configuration writes, accepted commands and results
   always @(posedge clock) begin
      if (reset) begin
         nodes_cfg  <= NODE_COUNT_RESET;
         y_term_cfg <= 1'b0;
         margin_cfg <= '0;
         load_ptr = 0;
         tri_a = 0; tri_b = 1; tri_c = 2;
         foreach (cut_counts[k]) cut_counts[k] = '0;
         expected_rsp.delete();
         fail_count = 0;
         triples_seen = 0;
         pending = 0;
      end else begin
         if (rsp_valid && rsp_ready) compare_result(rsp_payload);
         if (req_valid && req_ready) predict_command(req_payload);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NODE_COUNT: nodes_cfg  <= csr_wr_data[NODE_COUNT_W-1:0];
               CSR_USE_Y_TERM: y_term_cfg <= csr_wr_data[0];
               CSR_MARGIN:     margin_cfg <= csr_wr_data[MARGIN_W-1:0];
               default: ;
            endcase
         end
         pending = expected_rsp.size();
      end
   end
endmodule

FILE: verif/triangle_violation_scanner_top_tb.sv
`timescale 1ns / 1ps
module triangle_violation_scanner_top_tb;
   import tvs_pkg::*;

   localparam longint CYCLE_LIMIT = 4000000;
   localparam int     DRAIN_WAIT  = 24;
   localparam int     HOLD_CYCLES = 400;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;
   int   fail_count, pending, triples_seen;
   int   items_sent;
   int   tx_idle_pct = 11;
   int   rx_idle_pct = 51;
   int   hold_req = 0;
   int   hold_seen = 0;
   int   hold_off = 0;
   longint cycles = 0;
   int   full_sizes [3] = '{130, 190, 256};
   int   tier_loads [3] = '{170, 230, 320};

   tvs_stream_if #(.payload_type(req_payload_type)) req_if ();
   tvs_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   triangle_violation_scanner_top dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   triangle_violation_scanner_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_payload(req_if.payload),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_payload(rsp_if.payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending), .triples_seen(triples_seen)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_off <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Pick idle rates from how far the stimulus has come
   always @(posedge clock) begin
      if (items_sent < 450) begin
         tx_idle_pct <= 11; rx_idle_pct <= 51;
      end else if (items_sent < 900) begin
         tx_idle_pct <= 51; rx_idle_pct <= 11;
      end else begin
         tx_idle_pct <= 0; rx_idle_pct <= 0;
      end
   end

   // Offer one command and hold it until accepted; valid stays high after
   task automatic send_cmd(cmd_type c, logic [VALUE_W-1:0] v);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= '{cmd: c, edge_value: v};
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, int unsigned data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   // Hold the sender until all results are back and the block is idle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || !req_if.ready) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic configure(int n, int y, int margin);
      wait_idle();
      csr_write(CSR_NODE_COUNT, n);
      csr_write(CSR_USE_Y_TERM, y);
      csr_write(CSR_MARGIN, margin);
      csr_wr_en <= 1'b0;
   endtask

   // Edge values biased toward the region where cuts fire
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(4))
         0: return 17'd0;
         1: return 17'd65536;
         2: return VALUE_W'($urandom_range(65536));
         default: return VALUE_W'($urandom_range(65536, 30000));
      endcase
   endfunction

   function automatic int pick_margin();
      case ($urandom_range(5))
         0: return 0;
         1: return 65535;
         default: return $urandom_range(20000);
      endcase
   endfunction

   // Rewind, load the given number of pairs, with a little noise
   task automatic start_and_load(int loads);
      send_cmd(CMD_START, VALUE_W'($urandom));
      for (int k = 0; k < loads; k++) send_cmd(CMD_LOAD, pick_value());
      send_cmd(CMD_NOP, VALUE_W'($urandom));
   endtask

   task automatic examine_run(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 5) send_cmd(CMD_NOP, VALUE_W'($urandom));
         else if ($urandom_range(99) < 3) send_cmd(CMD_LOAD, pick_value());
         send_cmd(CMD_EXAMINE, VALUE_W'($urandom));
      end
   endtask

   initial begin
      int n, full;
      items_sent = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_NODE_COUNT;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: three nodes, one violated cut, then a finished scan
      configure(3, 1, 0);
      send_cmd(CMD_START, '0);
      send_cmd(CMD_LOAD, 17'd65536);
      send_cmd(CMD_LOAD, 17'd65536);
      send_cmd(CMD_LOAD, 17'd0);
      send_cmd(CMD_LOAD, 17'h1FFFF & 17'd65535);
      send_cmd(CMD_NOP, 17'h1FFFF);
      send_cmd(CMD_EXAMINE, '0);
      send_cmd(CMD_EXAMINE, '0);

      // Directed: four nodes at 1.0 against the largest margin
      configure(4, 0, 65535);
      send_cmd(CMD_START, '0);
      for (int k = 0; k < 6; k++) send_cmd(CMD_LOAD, 17'd65536);
      examine_run(5);

      // Directed: too few nodes, then no nodes at all
      configure(2, 1, 0);
      send_cmd(CMD_EXAMINE, '0);
      configure(0, 1, 0);
      send_cmd(CMD_LOAD, 17'd100);
      send_cmd(CMD_EXAMINE, '0);

      // Random scans on small graphs, some cut short
      while (items_sent < 300) begin
         n = $urandom_range(14, 5);
         full = (n * (n - 1) * (n - 2)) / 6;
         configure(n, $urandom_range(1), pick_margin());
         start_and_load((n * (n - 1)) / 2 + 1);
         if ($urandom_range(3) == 0) begin
            examine_run(full / 2);
            // shrink the graph mid-scan
            configure($urandom_range(n - 1, 3), $urandom_range(1), pick_margin());
            examine_run(full / 2);
         end else begin
            examine_run(full + 2);
         end
      end

      // Larger graphs hit each cut cap tier; only the leading pairs are loaded
      foreach (full_sizes[i]) begin
         configure(full_sizes[i], $urandom_range(1), $urandom_range(3000));
         start_and_load(tier_loads[i]);
         fork
            examine_run(40);
            if (i == 0) begin
               repeat (40) @(posedge clock);
               hold_req <= hold_req + 1;
            end
         join
      end

      // Count above the build maximum, then a mid-scan drop to a capped count
      configure(400, 1, 0);
      examine_run(20);
      configure(180, 0, 0);
      examine_run(20);

      wait_idle();
      $display("covered %0d commands, %0d triples checked", items_sent, triples_seen);
      $display("graphs of 0 to 256 nodes, all cap tiers, margins 0 to 65535");
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

FILE: sim.f
design/tvs_pkg.sv
design/tvs_stream_if.sv
design/tvs_ram.sv
design/tvs_ctrl.sv
design/tvs_datapath.sv
design/triangle_violation_scanner_top.sv
verif/triangle_violation_scanner_checker.sv
verif/triangle_violation_scanner_top_tb.sv
